[src/sqb_pkg.sv]
// ----------------------------------------------------------------------------
// sqb_pkg: shared types for the stack/queue buffer
// Action and status codes, plus the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sqb_pkg;

   typedef enum logic [2:0] {
      ACT_PUSH = 3'd0,
      ACT_POP  = 3'd1,
      ACT_SWAP = 3'd2,
      ACT_PEEK = 3'd3,
      ACT_DUMP = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SHORT = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic       push;        // store push value, advance pointers
      logic       pop;         // drop top value
      logic       rd_top;      // read top into port A, slot below into port B
      logic       load_walk;   // start a walk below the top
      logic       walk_one;    // walk covers the top value only (peek)
      logic       rd_ptr;      // read at walk pointer, advance walk
      logic       wr_top_b;    // write port B data at top
      logic       wr_below_a;  // write port A data below top
      logic       rsp_load;    // load the result register
      logic       rsp_data;    // result carries read data, else zero
      logic       rsp_walk;    // last flag follows the walk, else set
      status_type rsp_status;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic short_store;
      logic full;
      logic walk_last;
   } sts_type;

endpackage

[src/sqb_ctrl.sv]
// ----------------------------------------------------------------------------
// sqb_ctrl: sequencer for the stack/queue buffer
// Decodes each request transaction, drives datapath commands and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module sqb_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [2:0]      req_action,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output sqb_pkg::cmd_type cmd,
   input  sqb_pkg::sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_READ     = 4'b0010,
      ST_SWAP_WR1 = 4'b0100,
      ST_SWAP_WR2 = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.rsp_status = sqb_pkg::STAT_OK;
      state_in       = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               unique case (req_action)
                  sqb_pkg::ACT_PUSH: begin
                     cmd.rsp_load = 1'b1;
                     if (sts.full) begin
                        cmd.rsp_status = sqb_pkg::STAT_FULL;
                     end else begin
                        cmd.push = 1'b1;
                     end
                  end
                  sqb_pkg::ACT_POP: begin
                     cmd.rsp_load = 1'b1;
                     if (sts.empty) begin
                        cmd.rsp_status = sqb_pkg::STAT_EMPTY;
                     end else begin
                        cmd.pop = 1'b1;
                     end
                  end
                  sqb_pkg::ACT_SWAP: begin
                     cmd.rsp_load = 1'b1;
                     if (sts.short_store) begin
                        cmd.rsp_status = sqb_pkg::STAT_SHORT;
                     end else begin
                        cmd.rd_top = 1'b1;
                        state_in   = ST_SWAP_WR1;
                     end
                  end
                  sqb_pkg::ACT_PEEK: begin
                     if (sts.empty) begin
                        cmd.rsp_load   = 1'b1;
                        cmd.rsp_status = sqb_pkg::STAT_EMPTY;
                     end else begin
                        cmd.rd_top    = 1'b1;
                        cmd.load_walk = 1'b1;
                        cmd.walk_one  = 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  sqb_pkg::ACT_DUMP: begin
                     if (!sts.empty) begin
                        cmd.rd_top    = 1'b1;
                        cmd.load_walk = 1'b1;
                        state_in      = ST_READ;
                     end
                  end
                  default: begin
                     cmd.rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_data = 1'b1;
               cmd.rsp_walk = 1'b1;
               if (sts.walk_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_ptr = 1'b1;
               end
            end
         end
         ST_SWAP_WR1: begin
            cmd.wr_top_b = 1'b1;
            state_in     = ST_SWAP_WR2;
         end
         ST_SWAP_WR2: begin
            cmd.wr_below_a = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a stalled result is held");

   a_swap_writes: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_top_b |=> cmd.wr_below_a)
      else $error("swap did not finish with its second write");

   a_walk_stop: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_walk && sts.walk_last) |=> (state_ff == ST_IDLE))
      else $error("walk continued past its final value");

endmodule

[src/sqb_dp.sv]
// ----------------------------------------------------------------------------
// sqb_dp: datapath for the stack/queue buffer
// Value store, ring pointers, entry count, walk pointer and result register.
// ----------------------------------------------------------------------------
module sqb_dp #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   input  logic signed [31:0] req_push_value,
   input  sqb_pkg::cmd_type   cmd,
   output sqb_pkg::sts_type   sts,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUB_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
      return (i == '0) ? LAST_IDX : i - IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
   endfunction

   logic [31:0]        value_store_ff [DEPTH];
   logic [IDX_W-1:0]   top_ff, top_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               queue_mode_ff;
   logic [IDX_W-1:0]   walk_ptr_ff, walk_ptr_in;
   logic [CNT_W-1:0]   walk_left_ff, walk_left_in;
   logic [31:0]        rd_a_ff, rd_b_ff;
   logic [31:0]        rsp_value_ff;
   sqb_pkg::status_type rsp_status_ff;
   logic               rsp_last_ff;

   logic [IDX_W-1:0]   below_idx;
   logic [SUB_W-1:0]   tail_diff;
   logic [IDX_W-1:0]   tail_slot;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [31:0]        wr_data;
   logic               rd_a_en;
   logic [IDX_W-1:0]   rd_a_addr;

   assign below_idx = ring_prev(top_ff);

   // Slot just below the bottom value: top minus count, wrapped once
   assign tail_diff = SUB_W'(top_ff) - SUB_W'(count_ff);
   assign tail_slot = tail_diff[SUB_W-1] ? IDX_W'(tail_diff + SUB_W'(DEPTH))
                                         : IDX_W'(tail_diff);

   assign sts.empty       = (count_ff == '0);
   assign sts.short_store = (count_ff < CNT_W'(2));
   assign sts.full        = (count_ff == CNT_W'(DEPTH));
   assign sts.walk_last   = (walk_left_ff == CNT_W'(1));

   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         if (!queue_mode_ff) begin
            top_in = ring_next(top_ff);
         end
      end else if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = below_idx;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = top_ff;
      wr_data = rd_b_ff;
      if (cmd.push) begin
         wr_en   = 1'b1;
         wr_addr = queue_mode_ff ? tail_slot : ring_next(top_ff);
         wr_data = req_push_value;
      end else if (cmd.wr_top_b) begin
         wr_en   = 1'b1;
         wr_addr = top_ff;
         wr_data = rd_b_ff;
      end else if (cmd.wr_below_a) begin
         wr_en   = 1'b1;
         wr_addr = below_idx;
         wr_data = rd_a_ff;
      end
   end

   assign rd_a_en   = cmd.rd_top || cmd.rd_ptr;
   assign rd_a_addr = cmd.rd_top ? top_ff : walk_ptr_ff;

   always_comb begin
      walk_ptr_in  = walk_ptr_ff;
      walk_left_in = walk_left_ff;
      if (cmd.load_walk) begin
         walk_ptr_in  = below_idx;
         walk_left_in = cmd.walk_one ? CNT_W'(1) : count_ff;
      end else if (cmd.rd_ptr) begin
         walk_ptr_in  = ring_prev(walk_ptr_ff);
         walk_left_in = walk_left_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         value_store_ff[wr_addr] <= wr_data;
      end
      if (rd_a_en) begin
         rd_a_ff <= value_store_ff[rd_a_addr];
      end
      if (cmd.rd_top) begin
         rd_b_ff <= value_store_ff[below_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff        <= '0;
         count_ff      <= '0;
         queue_mode_ff <= 1'b0;
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
         if (csr_wr_en) begin
            queue_mode_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      walk_ptr_ff  <= walk_ptr_in;
      walk_left_ff <= walk_left_in;
      if (cmd.rsp_load) begin
         rsp_value_ff  <= cmd.rsp_data ? rd_a_ff : 32'd0;
         rsp_status_ff <= cmd.rsp_status;
         rsp_last_ff   <= cmd.rsp_walk ? sts.walk_last : 1'b1;
      end
   end

   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = 2'(rsp_status_ff);
   assign rsp_last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond store depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.full && !cmd.pop && !cmd.wr_top_b && !cmd.wr_below_a)
      else $error("push into a full store or against another write");

   a_walk_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_ptr |-> (walk_left_ff > CNT_W'(1)))
      else $error("walk read with no values left");

endmodule

[src/stack_queue_buffer.sv]
// Timing: push, pop, swap and unused actions give their one result from the
//   result register; peek and dump values pass the registered store read
//   first; further dump values follow one per cycle while rsp_stall is low.
// Throughput: one request per cycle for push/pop/no-op while rsp_stall is low;
//   swap holds the block for its two store writes; a dump, for all its values.
// Reset: synchronous, active high; empties the store and selects stack mode.
// ----------------------------------------------------------------------------
// stack_queue_buffer: bounded stack/queue of signed 32-bit values
// A ring of DEPTH entries with a top end. Push adds at the top (stack mode)
// or just below the bottom (queue mode); pop, peek, swap and dump act on the
// top. Store contents are undefined until written; only live slots reach a result.
// ----------------------------------------------------------------------------
module stack_queue_buffer #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_push_value,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_last,
   // configuration: queue_mode
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   sqb_pkg::cmd_type cmd;
   sqb_pkg::sts_type sts;

   // Controller: take one request transaction at a time, sequence store
   // reads and writes, hold the result valid flag until it is taken.
   sqb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Datapath: value store (one write port, two registered read ports),
   // top pointer, entry count, dump walk pointer and the result register.
   sqb_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

[verif/stack_queue_buffer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_queue_buffer_checker: result predictor and scoreboard
// Tracks every request and register write, keeps a private copy of the ring,
// and compares each result transaction field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module stack_queue_buffer_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [2:0]         req_action,
   input  logic signed [31:0] req_push_value,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_read_value,
   input  logic [1:0]         rsp_status,
   input  logic               rsp_last,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 results_checked
);

   localparam int DEPTH = 64;

   typedef struct packed {
      logic signed [31:0]  read_value;
      sqb_pkg::status_type status;
      logic                last;
   } buffer_result_type;

   buffer_result_type  expected_results[$];
   logic signed [31:0] slot_value[DEPTH];
   logic [5:0]         top_slot;
   logic [6:0]         fill_level;
   logic               queue_mode;
   int                 errors;
   int                 checked;

   function automatic void queue_result(logic signed [31:0] value,
                                        sqb_pkg::status_type st, logic lst);
      buffer_result_type r;
      r.read_value = value;
      r.status     = st;
      r.last       = lst;
      expected_results.push_back(r);
   endfunction

   // Ring of 64 slots: 6-bit slot arithmetic wraps on its own.
   task automatic apply_action(input logic [2:0] act, input logic signed [31:0] value);
      logic [5:0]         slot;
      logic signed [31:0] held;
      case (act)
         sqb_pkg::ACT_PUSH: begin
            if (fill_level >= DEPTH) begin
               queue_result('0, sqb_pkg::STAT_FULL, 1'b1);
            end else begin
               if (queue_mode) begin
                  slot = top_slot - fill_level[5:0];
               end else begin
                  top_slot = top_slot + 6'd1;
                  slot     = top_slot;
               end
               slot_value[slot] = value;
               fill_level       = fill_level + 7'd1;
               queue_result('0, sqb_pkg::STAT_OK, 1'b1);
            end
         end
         sqb_pkg::ACT_POP: begin
            if (fill_level == 0) begin
               queue_result('0, sqb_pkg::STAT_EMPTY, 1'b1);
            end else begin
               fill_level = fill_level - 7'd1;
               top_slot   = top_slot - 6'd1;
               queue_result('0, sqb_pkg::STAT_OK, 1'b1);
            end
         end
         sqb_pkg::ACT_SWAP: begin
            if (fill_level < 2) begin
               queue_result('0, sqb_pkg::STAT_SHORT, 1'b1);
            end else begin
               slot                 = top_slot - 6'd1;
               held                 = slot_value[top_slot];
               slot_value[top_slot] = slot_value[slot];
               slot_value[slot]     = held;
               queue_result('0, sqb_pkg::STAT_OK, 1'b1);
            end
         end
         sqb_pkg::ACT_PEEK: begin
            if (fill_level == 0)
               queue_result('0, sqb_pkg::STAT_EMPTY, 1'b1);
            else
               queue_result(slot_value[top_slot], sqb_pkg::STAT_OK, 1'b1);
         end
         sqb_pkg::ACT_DUMP: begin
            // empty store: no result at all
            for (int k = 0; k < fill_level; k++) begin
               slot = top_slot - 6'(k);
               queue_result(slot_value[slot], sqb_pkg::STAT_OK, k == fill_level - 1);
            end
         end
         default: queue_result('0, sqb_pkg::STAT_OK, 1'b1);
      endcase
   endtask

   always @(posedge clock) begin
      buffer_result_type want;
      if (reset) begin
         top_slot   = '0;
         fill_level = '0;
         queue_mode = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_wr_en)
            queue_mode = csr_wr_data;
         // results first: a request never answers in its own cycle
         if (rsp_valid && !rsp_stall) begin
            checked++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, expected none, got read_value %0d",
                        $time, rsp_read_value);
               $display("%0t:   status %0d last %0b", $time, rsp_status, rsp_last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value expected %0d got %0d",
                           $time, want.read_value, rsp_read_value);
               end
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d got %0d", $time, want.status, rsp_status);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %0b got %0b", $time, want.last, rsp_last);
               end
            end
         end
         if (req_valid && !req_stall)
            apply_action(req_action, req_push_value);
      end
      mismatch_count  <= errors;
      results_checked <= checked;
      pending_count   <= expected_results.size();
   end

endmodule

[verif/stack_queue_buffer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stack_queue_buffer_test: testbench top for the stack/queue buffer
// Drives directed corner requests and random push/pop/swap/peek/dump traffic
// in both push modes under three stall profiles; the checker beside the
// block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module stack_queue_buffer_test;

   // Unused action codes: the block answers them as a no-op.
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

   localparam int SETTLE_CYCLES   = 8;     // covers the swap write-back after its result
   localparam int HOLD_OFF_CYCLES = 400;   // long receiver hold-off
   localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no transaction at all

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic [2:0]         req_action     = sqb_pkg::ACT_PUSH;
   logic signed [31:0] req_push_value = '0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]         rsp_status;
   logic               rsp_last;
   logic               csr_wr_en      = 1'b0;
   logic               csr_wr_data    = 1'b0;

   int mismatch_total;
   int pending_results;
   int results_checked;
   int items_sent      = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   bit hold_off_req    = 1'b0;

   stack_queue_buffer u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   stack_queue_buffer_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .mismatch_count  (mismatch_total),
      .pending_count   (pending_results),
      .results_checked (results_checked)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly random values, with the signed extremes and small numbers mixed in.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return $signed(32'($urandom_range(0, 16))) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request transaction and hold it until the block takes it.
   // Called at a rising edge; returns at the edge of acceptance.
   task automatic send_req(input logic [2:0] act, input logic signed [31:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_push_value <= value;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   // Drop valid and wait until every predicted result has come back, then
   // let a few more cycles pass so a swap can finish its store writes.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the push mode only while the block is idle.
   task automatic write_mode(input logic mode);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Random traffic: long push bursts can fill the store past full, long pop
   // bursts can drain it past empty, and single mixed actions work on the middle.
   task automatic run_traffic(input int stop_at);
      int pick;
      int burst;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) begin
            burst = $urandom_range(40, 70);
            repeat (burst) send_req(sqb_pkg::ACT_PUSH, pick_value());
         end else if (pick == 2) begin
            burst = $urandom_range(20, 70);
            repeat (burst) send_req(sqb_pkg::ACT_POP, pick_value());
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               send_req(sqb_pkg::ACT_PUSH, pick_value());
            else if (pick < 55)
               send_req(sqb_pkg::ACT_POP, pick_value());
            else if (pick < 70)
               send_req(sqb_pkg::ACT_SWAP, pick_value());
            else if (pick < 85)
               send_req(sqb_pkg::ACT_PEEK, pick_value());
            else if (pick < 93)
               send_req(sqb_pkg::ACT_DUMP, pick_value());
            else
               send_req(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), pick_value());
         end
      end
   endtask

   // Receiver: random stalls, or a long hold-off when asked for one.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Watchdog: end the run if neither channel moves for too long.
   initial begin
      int quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("stack_queue_buffer: mismatch");
      $finish;
   end

   initial begin
      // first profile: sender idles a little, receiver stalls often
      send_idle_pct  = 11;
      recv_stall_pct = 56;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners in stack mode, straight after reset.
      send_req(sqb_pkg::ACT_POP, 32'sd0);            // pop when empty
      send_req(sqb_pkg::ACT_PEEK, 32'sd0);           // peek when empty
      send_req(sqb_pkg::ACT_SWAP, 32'sd0);           // swap when empty
      send_req(sqb_pkg::ACT_DUMP, 32'sd0);           // dump when empty: no result
      send_req(sqb_pkg::ACT_PUSH, 32'sh7FFF_FFFF);
      send_req(sqb_pkg::ACT_SWAP, 32'sd0);           // swap with a single value
      send_req(sqb_pkg::ACT_PEEK, 32'sd0);
      send_req(sqb_pkg::ACT_PUSH, 32'sh8000_0000);
      send_req(sqb_pkg::ACT_PUSH, -32'sd1);
      send_req(sqb_pkg::ACT_PUSH, 32'sd0);
      send_req(sqb_pkg::ACT_SWAP, -32'sd1);
      send_req(sqb_pkg::ACT_PEEK, 32'sd0);
      send_req(sqb_pkg::ACT_DUMP, 32'sd0);
      for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
         send_req(3'(a), -32'sd1);                   // unused codes
      send_req(sqb_pkg::ACT_POP, 32'sd0);
      send_req(sqb_pkg::ACT_PEEK, 32'sd0);
      send_req(sqb_pkg::ACT_POP, 32'sd0);
      send_req(sqb_pkg::ACT_POP, 32'sd0);
      send_req(sqb_pkg::ACT_POP, 32'sd0);
      send_req(sqb_pkg::ACT_DUMP, 32'sd0);

      // Queue mode under the first profile.
      write_mode(1'b1);
      run_traffic(170);

      // Stack mode, profile swapped: sender idles often, receiver rarely.
      write_mode(1'b0);
      send_idle_pct  = 56;
      recv_stall_pct = 11;
      run_traffic(320);

      // Queue mode at full speed, opening with a long receiver hold-off so
      // the block backs up and stalls its input.
      write_mode(1'b1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_off_req   = 1'b1;
      run_traffic(470);

      drain();
      $display("covered %0d requests over stack and queue modes, three stall profiles",
               items_sent);
      $display("and one long hold-off; %0d results compared", results_checked);
      if (mismatch_total == 0 && pending_results == 0)
         $display("stack_queue_buffer: match");
      else
         $display("stack_queue_buffer: mismatch");
      $finish;
   end

endmodule
